// ----- design/lps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;

	localparam int MAX_N       = 65536;
	localparam int PRIME_SLOTS = 8192;

	localparam int NUM_W  = 16;                    // number field
	localparam int LIM_W  = 17;                    // limit register
	localparam int ADDR_W = $clog2(MAX_N);         // mark store index
	localparam int PI_W   = $clog2(PRIME_SLOTS);   // prime list index
	localparam int CNT_W  = PI_W + 1;              // count reaches PRIME_SLOTS
	localparam int PROD_W = 2 * NUM_W;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(65536);
	localparam logic [LIM_W-1:0] MAX_N_LIM   = LIM_W'(MAX_N);
	localparam logic [LIM_W-1:0] FIRST_NUM   = LIM_W'(2);

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SEQ = 2'd1;
	localparam logic [1:0] ST_LIM = 2'd2;

	typedef struct packed {
		logic clr_wr;      // clearing pass write, advance address
		logic load_n;      // latch input word
		logic set_status;  // classify the latched word
		logic set_prime;   // word unmarked: flag and append
		logic j_clr;
		logic j_inc;
		logic mul;         // multiply number by fetched prime
		logic mark_wr;     // mark the product composite
		logic div_start;
		logic out_load;    // push result, commit sequence on ok
	} lps_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;         // status is not ok
		logic marked;
		logic j_end;
		logic prod_ge;
		logic div_busy;
		logic rem_zero;
		logic out_free;
	} lps_sts_t;

endpackage
`default_nettype wire

// ----- design/lps_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lps_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [lps_pkg::NUM_W-1:0]  dividend,
	input  wire [lps_pkg::NUM_W-1:0]  divisor,
	output logic                      busy,
	output logic                      rem_zero
);
	import lps_pkg::*;

	localparam int CW = $clog2(NUM_W) + 1;

	logic [NUM_W-1:0] dvd_q, dvs_q, rem_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W:0]   sh, diff;

	// restoring remainder, one dividend bit per cycle
	assign sh   = {rem_q, dvd_q[NUM_W-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			rem_q <= (sh >= {1'b0, dvs_q}) ? diff[NUM_W-1:0] : sh[NUM_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ----- design/lps_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lps_dp (
	input  wire                       clk,
	input  wire                       arst_n,
	input  lps_pkg::lps_cmd_t         cmd,
	output lps_pkg::lps_sts_t         sts,
	input  wire                       limit_we,
	input  wire [lps_pkg::LIM_W-1:0]  limit_wdata,
	input  wire [lps_pkg::NUM_W-1:0]  number,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic                      is_prime,
	output logic [lps_pkg::CNT_W-1:0] prime_count,
	output logic [1:0]                status
);
	import lps_pkg::*;

	logic [LIM_W-1:0]  limit_q, expected_q, lim_eff;
	logic [CNT_W-1:0]  cnt_q, j_q;
	logic [ADDR_W-1:0] clr_addr_q, mark_addr;
	logic [NUM_W-1:0]  n_q, p_q;
	logic [NUM_W-1:0]  plist_rd_q;
	logic [PROD_W-1:0] prod_s1;
	logic [1:0]        status_q;
	logic              prime_q, mark_rd_q, out_valid_q, div_busy, rem_zero;
	logic              marks [MAX_N];
	logic [NUM_W-1:0]  plist [PRIME_SLOTS];

	assign lim_eff = (limit_q > MAX_N_LIM) ? MAX_N_LIM : limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			expected_q  <= FIRST_NUM;
			cnt_q       <= '0;
			j_q         <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (limit_we) limit_q <= limit_wdata;
			if (cmd.clr_wr) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.set_prime && cnt_q < CNT_W'(PRIME_SLOTS)) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + CNT_W'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (status_q == ST_OK) expected_q <= expected_q + LIM_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_n) n_q <= number;
		if (cmd.set_status) begin
			prime_q  <= 1'b0;
			status_q <= ({1'b0, n_q} != expected_q) ? ST_SEQ :
			            ({1'b0, n_q} >= lim_eff)    ? ST_LIM : ST_OK;
		end
		if (cmd.set_prime) prime_q <= 1'b1;
		if (cmd.mul) begin
			prod_s1 <= n_q * plist_rd_q;
			p_q     <= plist_rd_q;
		end
		if (cmd.out_load) begin
			is_prime    <= prime_q;
			prime_count <= cnt_q;
			status      <= status_q;
		end
	end

	// composite marks: one write port, clearing pass or product mark
	assign mark_addr = cmd.clr_wr ? clr_addr_q : prod_s1[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.mark_wr) marks[mark_addr] <= ~cmd.clr_wr;
		mark_rd_q <= marks[n_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.set_prime && cnt_q < CNT_W'(PRIME_SLOTS)) plist[cnt_q[PI_W-1:0]] <= n_q;
		plist_rd_q <= plist[j_q[PI_W-1:0]];
	end

	lps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (p_q),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	assign out_valid    = out_valid_q;
	assign sts.clr_last = (clr_addr_q == ADDR_W'(MAX_N - 1));
	assign sts.bad      = (status_q != ST_OK);
	assign sts.marked   = mark_rd_q;
	assign sts.j_end    = (j_q >= cnt_q);
	assign sts.prod_ge  = (prod_s1 >= PROD_W'(lim_eff));
	assign sts.div_busy = div_busy;
	assign sts.rem_zero = rem_zero;
	assign sts.out_free = !out_valid_q || !out_stall;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result pushed over a pending word");
	a_prime_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_prime |-> (status_q == ST_OK))
		else $error("prime appended for a rejected word");
	a_mark_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> (prod_s1 < PROD_W'(lim_eff)))
		else $error("mark at or above limit");
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && status_q == ST_OK) |=>
		(expected_q == $past({1'b0, n_q}) + LIM_W'(1)))
		else $error("sequence not advanced");

endmodule
`default_nettype wire

// ----- design/lps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lps_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  lps_pkg::lps_sts_t  sts,
	output lps_pkg::lps_cmd_t  cmd
);
	import lps_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_MARK   = 8'b0000_1000,
		S_FETCH  = 8'b0001_0000,
		S_MUL    = 8'b0010_0000,
		S_PROD   = 8'b0100_0000,
		S_DIV    = 8'b1000_0000
	} st_t;

	st_t state_q, state_d;
	logic report_q, report_d;   // waiting to push the result

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			report_q <= report_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		report_d = report_q;
		cmd      = '0;
		in_stall = 1'b1;
		if (report_q) begin
			if (sts.out_free) begin
				cmd.out_load = 1'b1;
				report_d     = 1'b0;
				state_d      = S_IDLE;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					cmd.clr_wr = 1'b1;
					if (sts.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.load_n = 1'b1;
						state_d    = S_CHECK;
					end
				end
				S_CHECK: begin
					cmd.set_status = 1'b1;
					state_d        = S_MARK;
				end
				S_MARK: begin
					if (sts.bad) begin
						report_d = 1'b1;
					end else begin
						cmd.set_prime = !sts.marked;
						cmd.j_clr     = 1'b1;
						state_d       = S_FETCH;
					end
				end
				S_FETCH: begin
					if (sts.j_end) report_d = 1'b1;
					else state_d = S_MUL;
				end
				S_MUL: begin
					cmd.mul = 1'b1;
					state_d = S_PROD;
				end
				S_PROD: begin
					if (sts.prod_ge) begin
						report_d = 1'b1;
					end else begin
						cmd.mark_wr   = 1'b1;
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end
				S_DIV: begin
					if (!sts.div_busy) begin
						if (sts.rem_zero) begin
							report_d = 1'b1;
						end else begin
							cmd.j_inc = 1'b1;
							state_d   = S_FETCH;
						end
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		report_q |-> in_stall)
		else $error("input taken while a result is pending");
	a_no_cmd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!cmd.mark_wr && !cmd.out_load))
		else $error("work during clearing pass");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

endmodule
`default_nettype wire

// ----- design/linear_prime_sieve.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Linear (Euler) prime sieve.
// Input channel: in_valid / in_stall carry one word, the candidate "number".
//   Candidates must come in ascending order from 2; a word out of sequence
//   or at/above the limit gets status 1 or 2 and changes no state.
// Output channel: out_valid / out_stall carry one result word per input
//   word: is_prime, prime_count (primes found so far), status.
// Config: limit_we / limit_wdata write the exclusive limit (reset 65536,
//   values above 65536 act as 65536). Write only while the block is idle.
// Timing: one word is in work at a time. A taken word is latched and
//   classified; a rejected word goes straight to its result. An accepted
//   word walks the prime list: per prime a list read, a multiply, a compare
//   and mark, and the bit-serial remainder. The walk ends when the product
//   reaches the limit, the list runs out or the prime divides the word.
//   The result word is then registered as soon as the output is free.
// Reset: a clearing pass writes every composite mark to zero, one entry
//   per cycle; in_stall stays high during it.
// A stalled receiver holds the result in the output register; the next
//   word may be taken meanwhile but its result waits for the slot.
module linear_prime_sieve (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        limit_we,
	input  wire [lps_pkg::LIM_W-1:0]   limit_wdata,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [lps_pkg::NUM_W-1:0]   number,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       is_prime,
	output logic [lps_pkg::CNT_W-1:0]  prime_count,
	output logic [1:0]                 status
);
	import lps_pkg::*;

	lps_cmd_t cmd;
	lps_sts_t sts;

	// sequencer: clearing pass, classify, walk the prime list
	lps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, multiplier, remainder unit, output register
	lps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_prime    (is_prime),
		.prime_count (prime_count),
		.status      (status)
	);

endmodule
`default_nettype wire
